/* src/bqc_pkg.sv */
// ----------------------------------------------------------------------------
// bqc_pkg
// Constants, request types and saturation helpers shared by the biquad
// cascade filter modules.
// ----------------------------------------------------------------------------
package bqc_pkg;

  localparam int SECTIONS_PER_STAGE = 8;
  localparam int CHANNELS           = 2;

  localparam int NSECT  = 2 * SECTIONS_PER_STAGE;
  localparam int NSLOT  = 5;
  localparam int NCOEF  = NSLOT * NSECT;
  localparam int NDELAY = NSECT * CHANNELS;

  localparam int SEC_W   = $clog2(NSECT);
  localparam int CADDR_W = $clog2(NCOEF);
  localparam int DADDR_W = $clog2(NDELAY);

  localparam int SAMPLE_W = 24;
  localparam int COEF_W   = 32;
  localparam int STATE_W  = 40;
  localparam int FRAC     = 30;
  localparam int PROD_W   = COEF_W + SAMPLE_W;
  localparam int TERM_W   = PROD_W - FRAC;

  localparam logic [1:0] MODE_FILTER = 2'd0;
  localparam logic [1:0] MODE_COEF   = 2'd1;
  localparam logic [1:0] MODE_CLEAR  = 2'd2;

  localparam int SLOT_B0 = 0;
  localparam int SLOT_B1 = 1;
  localparam int SLOT_B2 = 2;
  localparam int SLOT_A1 = 3;
  localparam int SLOT_A2 = 4;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SEC,
    S_M0,
    S_Y,
    S_B1,
    S_A1,
    S_B2,
    S_A2,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]                 mode;
    logic                       channel;
    logic signed [SAMPLE_W-1:0] sample_in;
    logic [6:0]                 coef_index;
    logic signed [COEF_W-1:0]   coef_value;
    logic                       block_end;
  } item_t;

  typedef struct packed {
    logic                     en;
    logic [CADDR_W-1:0]       addr;
    logic signed [COEF_W-1:0] data;
  } coef_wr_t;

  typedef struct packed {
    logic                      en;
    logic [DADDR_W-1:0]        addr;
    logic signed [STATE_W-1:0] z1;
    logic signed [STATE_W-1:0] z2;
  } delay_wr_t;

  typedef struct packed {
    logic                       valid;
    logic                       channel;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       clip;
    logic                       block_end;
  } result_t;

  localparam logic signed [40:0] Y_MAX = 41'sd8388607;
  localparam logic signed [40:0] Y_MIN = -41'sd8388608;
  localparam logic signed [42:0] Z_MAX = 43'sd549755813887;
  localparam logic signed [42:0] Z_MIN = -43'sd549755813888;

  function automatic logic ovf24(logic signed [40:0] v);
    return (v > Y_MAX) || (v < Y_MIN);
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] sat24(logic signed [40:0] v);
    logic signed [SAMPLE_W-1:0] r;
    if (v > Y_MAX) begin
      r = SAMPLE_W'(Y_MAX);
    end else if (v < Y_MIN) begin
      r = SAMPLE_W'(Y_MIN);
    end else begin
      r = v[SAMPLE_W-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [STATE_W-1:0] sat40(logic signed [42:0] v);
    logic signed [STATE_W-1:0] r;
    if (v > Z_MAX) begin
      r = STATE_W'(Z_MAX);
    end else if (v < Z_MIN) begin
      r = STATE_W'(Z_MIN);
    end else begin
      r = v[STATE_W-1:0];
    end
    return r;
  endfunction

endpackage

/* src/bqc_coef_ram.sv */
// ----------------------------------------------------------------------------
// bqc_coef_ram
// Coefficient table: one write port, one registered read port, with a
// valid bit per entry so that unwritten entries read as zero after reset.
// ----------------------------------------------------------------------------
module bqc_coef_ram (
  input  logic                              clk,
  input  logic                              rst,
  input  bqc_pkg::coef_wr_t                 wr,
  input  logic                              re,
  input  logic [bqc_pkg::CADDR_W-1:0]       raddr,
  output logic signed [bqc_pkg::COEF_W-1:0] rdata
);

  logic signed [bqc_pkg::COEF_W-1:0] mem [bqc_pkg::NCOEF];
  logic [bqc_pkg::NCOEF-1:0]         valid;
  logic signed [bqc_pkg::COEF_W-1:0] rd_q;
  logic                              rd_valid;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (re) begin
      rd_q <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (wr.en) begin
        valid[wr.addr] <= 1'b1;
      end
      if (re) begin
        rd_valid <= valid[raddr];
      end
    end
  end

  assign rdata = rd_valid ? rd_q : '0;

endmodule

/* src/bqc_delay_ram.sv */
// ----------------------------------------------------------------------------
// bqc_delay_ram
// Section state store holding z1 and z2 per section and channel, with valid
// bits that reset and the clear request drop all at once.
// ----------------------------------------------------------------------------
module bqc_delay_ram (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               clear,
  input  bqc_pkg::delay_wr_t                 wr,
  input  logic                               re,
  input  logic [bqc_pkg::DADDR_W-1:0]        raddr,
  output logic signed [bqc_pkg::STATE_W-1:0] z1,
  output logic signed [bqc_pkg::STATE_W-1:0] z2
);

  logic [2*bqc_pkg::STATE_W-1:0] mem [bqc_pkg::NDELAY];
  logic [bqc_pkg::NDELAY-1:0]    valid;
  logic [2*bqc_pkg::STATE_W-1:0] rd_q;
  logic                          rd_valid;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= {wr.z1, wr.z2};
    end
    if (re) begin
      rd_q <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (clear) begin
        valid <= '0;
      end else if (wr.en) begin
        valid[wr.addr] <= 1'b1;
      end
      if (re) begin
        rd_valid <= valid[raddr];
      end
    end
  end

  assign z1 = rd_valid ? $signed(rd_q[2*bqc_pkg::STATE_W-1:bqc_pkg::STATE_W]) : '0;
  assign z2 = rd_valid ? $signed(rd_q[bqc_pkg::STATE_W-1:0]) : '0;

endmodule

/* src/bqc_engine.sv */
// ----------------------------------------------------------------------------
// bqc_engine
// Section sequencer and shared multiply-accumulate datapath: walks the
// sections, reads coefficients and state, and writes the new state back.
// ----------------------------------------------------------------------------
module bqc_engine (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  bqc_pkg::item_t                     item,
  input  logic [15:0]                        section_enable,
  output logic                               busy,
  output bqc_pkg::result_t                   result,
  input  logic                               result_take,
  output bqc_pkg::coef_wr_t                  coef_wr,
  output logic                               coef_re,
  output logic [bqc_pkg::CADDR_W-1:0]        coef_raddr,
  input  logic signed [bqc_pkg::COEF_W-1:0]  coef_rdata,
  output logic                               delay_clear,
  output logic                               delay_re,
  output logic [bqc_pkg::DADDR_W-1:0]        delay_raddr,
  output bqc_pkg::delay_wr_t                 delay_wr,
  input  logic signed [bqc_pkg::STATE_W-1:0] z1_rd,
  input  logic signed [bqc_pkg::STATE_W-1:0] z2_rd
);

  bqc_pkg::state_t state, state_next;

  logic [bqc_pkg::SEC_W-1:0]          sec;
  logic                               ch;
  logic                               blk;
  logic                               clip;
  logic signed [bqc_pkg::SAMPLE_W-1:0] x;
  logic signed [bqc_pkg::SAMPLE_W-1:0] y;
  logic signed [bqc_pkg::PROD_W-1:0]   prod;
  logic signed [41:0]                 acc;
  logic signed [bqc_pkg::STATE_W-1:0] z1n;

  logic [31:0]                        en_wide;
  logic                               sec_on;
  logic                               sec_last;
  logic                               ch_ok;
  logic                               use_y;
  logic                               delay_we;
  int                                 slot;
  logic [bqc_pkg::CADDR_W-1:0]        coef_base;
  logic signed [bqc_pkg::SAMPLE_W-1:0] mul_x;
  logic signed [bqc_pkg::TERM_W-1:0]   p_hi;
  logic signed [40:0]                 y_sum;
  logic signed [42:0]                 z_diff;

  assign en_wide   = {16'b0, section_enable} >> sec;
  assign sec_on    = en_wide[0];
  assign sec_last  = (32'(sec) == bqc_pkg::NSECT - 1);
  assign ch_ok     = (32'(item.channel) < bqc_pkg::CHANNELS);
  assign coef_base = bqc_pkg::CADDR_W'(32'(sec) * bqc_pkg::NSLOT);
  assign coef_raddr  = coef_base + bqc_pkg::CADDR_W'(slot);
  assign delay_raddr = bqc_pkg::DADDR_W'(32'(sec) * bqc_pkg::CHANNELS + 32'(ch));

  assign mul_x  = use_y ? y : x;
  assign p_hi   = prod[bqc_pkg::PROD_W-1:bqc_pkg::FRAC];
  assign y_sum  = 41'(p_hi) + 41'(z1_rd);
  assign z_diff = 43'(acc) - 43'(p_hi);

  assign coef_wr.en   = start && (item.mode == bqc_pkg::MODE_COEF) &&
                        (32'(item.coef_index) < bqc_pkg::NCOEF);
  assign coef_wr.addr = bqc_pkg::CADDR_W'(item.coef_index);
  assign coef_wr.data = item.coef_value;
  assign delay_clear  = start && (item.mode == bqc_pkg::MODE_CLEAR);

  assign delay_wr.en   = delay_we;
  assign delay_wr.addr = delay_raddr;
  assign delay_wr.z1   = z1n;
  assign delay_wr.z2   = bqc_pkg::sat40(z_diff);

  assign busy             = (state != bqc_pkg::S_IDLE);
  assign result.valid     = (state == bqc_pkg::S_DONE);
  assign result.channel   = ch;
  assign result.sample    = x;
  assign result.clip      = clip;
  assign result.block_end = blk;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bqc_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    coef_re    = 1'b0;
    slot       = bqc_pkg::SLOT_B0;
    delay_re   = 1'b0;
    delay_we   = 1'b0;
    use_y      = 1'b0;
    case (state)
      bqc_pkg::S_IDLE: begin
        if (start && (item.mode == bqc_pkg::MODE_FILTER) && ch_ok) begin
          state_next = bqc_pkg::S_SEC;
        end
      end
      bqc_pkg::S_SEC: begin
        if (sec_on) begin
          coef_re    = 1'b1;
          delay_re   = 1'b1;
          state_next = bqc_pkg::S_M0;
        end else if (sec_last) begin
          state_next = bqc_pkg::S_DONE;
        end
      end
      bqc_pkg::S_M0: begin
        coef_re    = 1'b1;
        slot       = bqc_pkg::SLOT_B1;
        state_next = bqc_pkg::S_Y;
      end
      bqc_pkg::S_Y: begin
        coef_re    = 1'b1;
        slot       = bqc_pkg::SLOT_A1;
        state_next = bqc_pkg::S_B1;
      end
      bqc_pkg::S_B1: begin
        coef_re    = 1'b1;
        slot       = bqc_pkg::SLOT_B2;
        use_y      = 1'b1;
        state_next = bqc_pkg::S_A1;
      end
      bqc_pkg::S_A1: begin
        coef_re    = 1'b1;
        slot       = bqc_pkg::SLOT_A2;
        state_next = bqc_pkg::S_B2;
      end
      bqc_pkg::S_B2: begin
        use_y      = 1'b1;
        state_next = bqc_pkg::S_A2;
      end
      bqc_pkg::S_A2: begin
        delay_we   = 1'b1;
        state_next = sec_last ? bqc_pkg::S_DONE : bqc_pkg::S_SEC;
      end
      bqc_pkg::S_DONE: begin
        if (result_take) begin
          state_next = bqc_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = bqc_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= bqc_pkg::PROD_W'(coef_rdata) * bqc_pkg::PROD_W'(mul_x);
    if (start) begin
      ch   <= item.channel;
      blk  <= item.block_end;
      x    <= item.sample_in;
      clip <= 1'b0;
      sec  <= '0;
    end
    case (state)
      bqc_pkg::S_SEC: begin
        if (!sec_on && !sec_last) begin
          sec <= sec + 1'b1;
        end
      end
      bqc_pkg::S_Y: begin
        y    <= bqc_pkg::sat24(y_sum);
        clip <= clip | bqc_pkg::ovf24(y_sum);
      end
      bqc_pkg::S_B1: begin
        acc <= 42'(p_hi) + 42'(z2_rd);
      end
      bqc_pkg::S_A1: begin
        z1n <= bqc_pkg::sat40(z_diff);
      end
      bqc_pkg::S_B2: begin
        acc <= 42'(p_hi);
      end
      bqc_pkg::S_A2: begin
        x <= y;
        if (!sec_last) begin
          sec <= sec + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

/* src/biquad_cascade_filter.sv */
// ----------------------------------------------------------------------------
// biquad_cascade_filter
// Per-channel cascade of sixteen transposed direct form II biquad sections
// with 24-bit samples, Q2.30 coefficients and 40-bit section state. A
// coefficient or clear request is applied on acceptance and leaves the
// block idle. A sample request holds the input stalled until its result
// has gone to the output register: the sequencer visits every section and
// steps each enabled one through states M0, Y, B1, A1, B2 and A2, using
// the single shared 32x24 multiplier and the one read port of the
// coefficient memory. The result sits in an output register, so the next
// request is taken while it waits. Coefficients and state are held in
// memories whose valid bits clear at reset; no clearing pass is needed.
// ----------------------------------------------------------------------------
module biquad_cascade_filter (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [15:0]                         cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          mode,
  input  logic                                channel,
  input  logic signed [bqc_pkg::SAMPLE_W-1:0] sample_in,
  input  logic [6:0]                          coef_index,
  input  logic signed [bqc_pkg::COEF_W-1:0]   coef_value,
  input  logic                                block_end,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_channel,
  output logic signed [bqc_pkg::SAMPLE_W-1:0] sample_out,
  output logic                                clipped,
  output logic                                out_block_end
);

  logic [15:0]                        section_enable;
  logic                               busy;
  logic                               start;
  logic                               result_take;
  bqc_pkg::item_t                     item;
  bqc_pkg::result_t                   result;
  bqc_pkg::coef_wr_t                  coef_wr;
  logic                               coef_re;
  logic [bqc_pkg::CADDR_W-1:0]        coef_raddr;
  logic signed [bqc_pkg::COEF_W-1:0]  coef_rdata;
  logic                               delay_clear;
  logic                               delay_re;
  logic [bqc_pkg::DADDR_W-1:0]        delay_raddr;
  bqc_pkg::delay_wr_t                 delay_wr;
  logic signed [bqc_pkg::STATE_W-1:0] z1_rd;
  logic signed [bqc_pkg::STATE_W-1:0] z2_rd;

  assign cfg_ready   = 1'b1;
  assign in_stall    = busy;
  assign start       = in_valid && !in_stall;
  assign result_take = !out_valid || !out_stall;

  assign item.mode       = mode;
  assign item.channel    = channel;
  assign item.sample_in  = sample_in;
  assign item.coef_index = coef_index;
  assign item.coef_value = coef_value;
  assign item.block_end  = block_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      section_enable <= '0;
    end else if (cfg_valid && cfg_ready) begin
      section_enable <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (result.valid && result_take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (result.valid && result_take) begin
      out_channel   <= result.channel;
      sample_out    <= result.sample;
      clipped       <= result.clip;
      out_block_end <= result.block_end;
    end
  end

  bqc_engine u_engine (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .item           (item),
    .section_enable (section_enable),
    .busy           (busy),
    .result         (result),
    .result_take    (result_take),
    .coef_wr        (coef_wr),
    .coef_re        (coef_re),
    .coef_raddr     (coef_raddr),
    .coef_rdata     (coef_rdata),
    .delay_clear    (delay_clear),
    .delay_re       (delay_re),
    .delay_raddr    (delay_raddr),
    .delay_wr       (delay_wr),
    .z1_rd          (z1_rd),
    .z2_rd          (z2_rd)
  );

  bqc_coef_ram u_coef_ram (
    .clk   (clk),
    .rst   (rst),
    .wr    (coef_wr),
    .re    (coef_re),
    .raddr (coef_raddr),
    .rdata (coef_rdata)
  );

  bqc_delay_ram u_delay_ram (
    .clk   (clk),
    .rst   (rst),
    .clear (delay_clear),
    .wr    (delay_wr),
    .re    (delay_re),
    .raddr (delay_raddr),
    .z1    (z1_rd),
    .z2    (z2_rd)
  );

endmodule

/* test/biquad_cascade_filter_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// biquad_cascade_filter_tb
// Self-checking bench for the biquad cascade filter. A queue-fed driver sends
// filter, coefficient, clear and unused-mode requests with random gaps. A
// clocked monitor predicts every filtered sample from a local copy of the
// coefficient table, the section state and the enable register, and checks
// each result in order. The output side stalls at random, once for a long
// stretch so that the block backs up. The section enables change between
// phases, only once the block has gone idle.
// ----------------------------------------------------------------------------
module biquad_cascade_filter_tb;
  import bqc_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 150;
  localparam int CYCLE_LIMIT = 1500000;
  localparam int RANDOM_REQS = 1000;
  localparam int LONG_HOLD = 800;
  localparam longint ONE_Q30 = longint'(1) <<< FRAC;

  typedef struct {
    logic                       ch;
    logic signed [SAMPLE_W-1:0] smp;
    logic                       clip;
    logic                       blk;
  } filtered_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [15:0]                cfg_data = '0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic [1:0]                 mode = MODE_FILTER;
  logic                       channel = 1'b0;
  logic signed [SAMPLE_W-1:0] sample_in = '0;
  logic [6:0]                 coef_index = '0;
  logic signed [COEF_W-1:0]   coef_value = '0;
  logic                       block_end = 1'b0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic                       out_channel;
  logic signed [SAMPLE_W-1:0] sample_out;
  logic                       clipped;
  logic                       out_block_end;

  logic signed [COEF_W-1:0]  coef_table [NCOEF];
  logic signed [STATE_W-1:0] z1_store [NDELAY];
  logic signed [STATE_W-1:0] z2_store [NDELAY];
  logic [15:0]               enable_reg = '0;

  item_t     pending_reqs[$];
  item_t     cur_req;
  filtered_t filtered_expect[$];

  int  reqs_pushed = 0;
  int  reqs_accepted = 0;
  int  mismatches = 0;
  int  cycle_count = 0;
  int  tx_gap_left = 0;
  int  rx_stall_left = 0;
  int  hold_req = 0;
  int  hold_left = 0;
  bit  req_taken = 1'b0;
  bit  cfg_taken = 1'b0;
  bit  tx_idle_on = 1'b1;
  bit  rx_idle_on = 1'b1;

  biquad_cascade_filter u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .mode         (mode),
    .channel      (channel),
    .sample_in    (sample_in),
    .coef_index   (coef_index),
    .coef_value   (coef_value),
    .block_end    (block_end),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_channel  (out_channel),
    .sample_out   (sample_out),
    .clipped      (clipped),
    .out_block_end(out_block_end)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic longint scale_q30(logic signed [COEF_W-1:0] c, longint v);
    longint p;
    p = longint'(c) * v;
    return p >>> FRAC;
  endfunction

  function automatic longint clamp_to(longint v, int w);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (w - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) begin
      return hi;
    end else if (v < lo) begin
      return lo;
    end
    return v;
  endfunction

  function automatic void clear_sections();
    for (int i = 0; i < NDELAY; i++) begin
      z1_store[i] = '0;
      z2_store[i] = '0;
    end
  endfunction

  function automatic void predict_request(item_t r);
    longint    x;
    longint    y;
    longint    acc;
    int        d;
    int        c;
    bit        clip;
    filtered_t f;
    case (r.mode)
      MODE_COEF: begin
        if (r.coef_index < NCOEF) coef_table[r.coef_index] = r.coef_value;
      end
      MODE_CLEAR: begin
        clear_sections();
      end
      MODE_FILTER: begin
        x = longint'($signed(r.sample_in));
        clip = 1'b0;
        for (int s = 0; s < NSECT; s++) begin
          if (enable_reg[s]) begin
            d = s * CHANNELS + r.channel;
            c = NSLOT * s;
            acc = scale_q30(coef_table[c + SLOT_B0], x) + z1_store[d];
            y = clamp_to(acc, SAMPLE_W);
            if (y != acc) clip = 1'b1;
            z1_store[d] = STATE_W'(clamp_to(scale_q30(coef_table[c + SLOT_B1], x)
                          - scale_q30(coef_table[c + SLOT_A1], y) + z2_store[d], STATE_W));
            z2_store[d] = STATE_W'(clamp_to(scale_q30(coef_table[c + SLOT_B2], x)
                          - scale_q30(coef_table[c + SLOT_A2], y), STATE_W));
            x = y;
          end
        end
        f.ch = r.channel;
        f.smp = SAMPLE_W'(x);
        f.clip = clip;
        f.blk = r.block_end;
        filtered_expect.push_back(f);
      end
      default: begin
      end
    endcase
  endfunction

  function automatic int pick_idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 4))
      0: return SAMPLE_W'(int'($urandom_range(0, 2000)) - 1000);
      1: return SAMPLE_W'(int'($urandom_range(0, 1 << 21)) - (1 << 20));
      2: return $urandom_range(0, 1) ? 24'sh7FFFFF : 24'sh800000;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  // Driver: advance on acceptance, then hold the line idle for the chosen gap
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || req_taken) begin
      req_taken = 1'b0;
      if (tx_gap_left > 0) begin
        tx_gap_left--;
        in_valid <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        cur_req = pending_reqs.pop_front();
        mode <= cur_req.mode;
        channel <= cur_req.channel;
        sample_in <= cur_req.sample_in;
        coef_index <= cur_req.coef_index;
        coef_value <= cur_req.coef_value;
        block_end <= cur_req.block_end;
        in_valid <= 1'b1;
        tx_gap_left = tx_idle_on ? pick_idle_len() : 0;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (rx_stall_left > 0) begin
      rx_stall_left--;
      out_stall <= 1'b1;
    end else if (rx_idle_on && $urandom_range(0, 99) < 30) begin
      rx_stall_left = pick_idle_len();
      out_stall <= (rx_stall_left > 0);
      if (rx_stall_left > 0) rx_stall_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    filtered_t e;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        enable_reg = cfg_data;
        cfg_taken = 1'b1;
      end
      if (out_valid && !out_stall) begin
        if (filtered_expect.size() == 0) begin
          $error("unexpected result: channel %0d sample %0d", out_channel, sample_out);
          mismatches++;
        end else begin
          e = filtered_expect.pop_front();
          if (out_channel !== e.ch) begin
            $error("out_channel: expected %0d, got %0d", e.ch, out_channel);
            mismatches++;
          end
          if (sample_out !== e.smp) begin
            $error("sample_out: expected %0d, got %0d", e.smp, sample_out);
            mismatches++;
          end
          if (clipped !== e.clip) begin
            $error("clipped: expected %0d, got %0d", e.clip, clipped);
            mismatches++;
          end
          if (out_block_end !== e.blk) begin
            $error("out_block_end: expected %0d, got %0d", e.blk, out_block_end);
            mismatches++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        predict_request(cur_req);
        reqs_accepted++;
        req_taken = 1'b1;
      end
    end
  end

  task automatic push_req(logic [1:0] m, logic ch, logic signed [SAMPLE_W-1:0] smp,
                          logic [6:0] idx, logic signed [COEF_W-1:0] val, logic blk);
    item_t r;
    r.mode = m;
    r.channel = ch;
    r.sample_in = smp;
    r.coef_index = idx;
    r.coef_value = val;
    r.block_end = blk;
    pending_reqs.push_back(r);
    reqs_pushed++;
  endtask

  task automatic push_sample(logic ch, logic signed [SAMPLE_W-1:0] smp, logic blk);
    push_req(MODE_FILTER, ch, smp, 7'($urandom), COEF_W'($urandom), blk);
  endtask

  task automatic push_coef(int idx, longint val);
    push_req(MODE_COEF, 1'($urandom), SAMPLE_W'($urandom), 7'(idx), COEF_W'(val),
             1'($urandom));
  endtask

  task automatic push_clear();
    push_req(MODE_CLEAR, 1'($urandom), SAMPLE_W'($urandom), 7'($urandom),
             COEF_W'($urandom), 1'($urandom));
  endtask

  // Mostly stable sections, now and then arbitrary coefficients
  task automatic push_biquad(int s);
    longint b0, b1, b2, a1, a2, lim;
    if ($urandom_range(0, 5) == 0) begin
      b0 = longint'($signed($urandom));
      b1 = longint'($signed($urandom));
      b2 = longint'($signed($urandom));
      a1 = longint'($signed($urandom));
      a2 = longint'($signed($urandom));
    end else begin
      b0 = longint'($urandom_range(0, 32'h4000_0000)) - (ONE_Q30 >>> 1);
      b1 = longint'($urandom_range(0, 32'h8000_0000)) - ONE_Q30;
      b2 = longint'($urandom_range(0, 32'h4000_0000)) - (ONE_Q30 >>> 1);
      a2 = longint'($urandom_range(0, 1717986918)) - 858993459;
      lim = (ONE_Q30 + a2) * 9 / 10;
      a1 = longint'($urandom_range(0, 32'(2 * lim))) - lim;
    end
    push_coef(NSLOT * s + SLOT_B0, b0);
    push_coef(NSLOT * s + SLOT_B1, b1);
    push_coef(NSLOT * s + SLOT_B2, b2);
    push_coef(NSLOT * s + SLOT_A1, a1);
    push_coef(NSLOT * s + SLOT_A2, a2);
  endtask

  task automatic wait_drained();
    while (reqs_accepted != reqs_pushed || filtered_expect.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_section_enable(logic [15:0] bits);
    @(negedge clk);
    cfg_taken = 1'b0;
    cfg_valid <= 1'b1;
    cfg_data <= bits;
    do @(negedge clk); while (!cfg_taken);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int          random_reqs;
    int          phase;
    int          n;
    logic [15:0] en_bits;
    item_t       r;
    for (int i = 0; i < NCOEF; i++) coef_table[i] = '0;
    clear_sections();
    random_reqs = 0;
    phase = 0;
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    // Directed: extreme coefficients and samples, ignored writes, unused mode
    set_section_enable(16'h8001);
    push_coef(NSLOT * 0 + SLOT_B0, 32'sh7FFF_FFFF);
    push_coef(NSLOT * 15 + SLOT_B0, -64'sd2147483648);
    push_coef(NSLOT * 15 + SLOT_A1, 32'sh4000_0000);
    push_coef(NSLOT * 15 + SLOT_A2, 32'sh2000_0000);
    push_coef(NSLOT * 0 + SLOT_B1, -64'sd2147483648);
    push_coef(NCOEF, 32'sh1234_5678);
    push_coef(127, longint'($signed($urandom)));
    push_sample(1'b0, 24'sh7FFFFF, 1'b0);
    push_sample(1'b1, 24'sh800000, 1'b1);
    push_sample(1'b0, 24'sh000000, 1'b0);
    push_sample(1'b1, -24'sd1, 1'b1);
    push_req(MODE_UNUSED, 1'b1, 24'sh7FFFFF, 7'd127, 32'sh7FFF_FFFF, 1'b1);
    push_clear();
    push_sample(1'b0, 24'sd1, 1'b1);
    push_sample(1'b1, 24'sh7FFFFF, 1'b0);
    push_coef(NSLOT * 0 + SLOT_B0, 0);
    push_sample(1'b0, 24'sh800000, 1'b1);
    wait_drained();

    while (random_reqs < RANDOM_REQS) begin
      case (phase % 6)
        0: en_bits = 16'hFFFF;
        1: en_bits = 16'h0000;
        2: en_bits = 16'h00FF;
        3: en_bits = 16'hFF00;
        default: en_bits = 16'($urandom);
      endcase
      set_section_enable(en_bits);
      tx_idle_on = (phase % 5 != 4) && ($urandom_range(0, 3) != 0);
      rx_idle_on = (phase % 5 != 4) && ($urandom_range(0, 3) != 0);

      if (phase == 3) begin
        // Hold the output off and offer samples back to back so that the input stalls
        tx_idle_on = 1'b0;
        @(posedge clk);
        hold_req = LONG_HOLD;
        for (int i = 0; i < 40; i++) begin
          push_sample(1'($urandom), pick_sample(), 1'(i % 8 == 7));
        end
        random_reqs += 40;
      end else if ($urandom_range(0, 9) < 7) begin
        n = $urandom_range(1, 4);
        for (int k = 0; k < n; k++) push_biquad($urandom_range(0, NSECT - 1));
        random_reqs += 5 * n;
        if ($urandom_range(0, 1)) begin
          push_clear();
          random_reqs++;
        end
        n = $urandom_range(20, 50);
        for (int i = 0; i < n; i++) begin
          push_sample(1'($urandom), pick_sample(), 1'($urandom_range(0, 7) == 0));
        end
        random_reqs += n;
      end else begin
        for (int i = 0; i < 30; i++) begin
          r.mode = 2'($urandom_range(0, 3));
          r.coef_index = 7'($urandom_range(0, 127));
          push_req(r.mode, 1'($urandom), SAMPLE_W'($urandom), r.coef_index,
                   COEF_W'($urandom), 1'($urandom));
          if (r.mode == MODE_FILTER || r.mode == MODE_CLEAR ||
              (r.mode == MODE_COEF && r.coef_index < NCOEF)) random_reqs++;
        end
      end
      wait_drained();
      phase++;
    end

    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* biquad_cascade_filter.f */
src/bqc_pkg.sv
src/bqc_coef_ram.sv
src/bqc_delay_ram.sv
src/bqc_engine.sv
src/biquad_cascade_filter.sv
test/biquad_cascade_filter_tb.sv
